[src/imt_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the arctangent table for imu_rate_and_tilt.
// No dependencies.
package imt_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int SQRT_STEPS        = 24;
    localparam int RATE_STAGES       = 3;

    localparam int AXIS_W  = 16;
    localparam int ANGLE_W = 15;
    localparam int CFG_A_W = 3;
    localparam int CFG_D_W = 16;
    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 80;

    localparam logic [CFG_A_W-1:0] REG_OVR_EN     = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_OVR_ROLL_R = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_OVR_PITCH_R = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_OVR_YAW_R  = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_OVR_ROLL_A = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_OVR_PITCH_A = 3'd5;

    localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 15'sd11520;

    // 128/131 by reciprocal: floor(x * RATE_RECIP / 2^30) == floor(x / 131) for x < 2^23
    localparam logic [23:0] RATE_RECIP = 24'd8196503;
    localparam logic [23:0] RATE_BIAS  = 24'd65;

    typedef logic signed [AXIS_W-1:0]  axis_t;
    typedef logic signed [ANGLE_W-1:0] angle_t;

    function automatic logic [21:0] imt_atan(input int i);
        logic [21:0] v;
        case (i)
            0:  v = 22'd2949120;
            1:  v = 22'd1740967;
            2:  v = 22'd919879;
            3:  v = 22'd466945;
            4:  v = 22'd234379;
            5:  v = 22'd117304;
            6:  v = 22'd58666;
            7:  v = 22'd29335;
            8:  v = 22'd14668;
            9:  v = 22'd7334;
            10: v = 22'd3667;
            11: v = 22'd1833;
            12: v = 22'd917;
            13: v = 22'd458;
            14: v = 22'd229;
            15: v = 22'd115;
            16: v = 22'd57;
            17: v = 22'd29;
            18: v = 22'd14;
            19: v = 22'd7;
            20: v = 22'd4;
            21: v = 22'd2;
            22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

[src/imu_rate_and_tilt.sv]
`timescale 1ns / 1ps
// imu_rate_and_tilt: one IMU sample in, body rates and accelerometer tilt out.
// Depends on imt_pkg, imt_tilt, imt_rate.
//
// Input stream s_*: one transaction per sample, six signed 16-bit axes.
// Output stream m_*: one transaction per sample, three rates (1/128 deg/s)
// and roll/pitch tilt (1/128 degree), in input order.
// The pipe has one squaring stage, 24 square-root stages, one stage per
// CORDIC rotation and a rounding stage.
// Throughput is one sample per cycle unless m_tready stalls the pipe; every stage is a register.
// When the receiver holds m_tready low with a result waiting, the whole pipe
// freezes and s_tready drops in the same cycle; nothing is lost or repeated.
// Reset clears the valid chain and the override registers.
// The cfg_* port writes registers 0..5 (override enable, three forced rates,
// two forced angles); write only while the pipe is empty. Forced angles are
// saturated to +-90 degrees on the output.
module imu_rate_and_tilt #(
    parameter int CORDIC_STAGES = imt_pkg::CORDIC_STAGES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
    input  logic [imt_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // roll_rate, pitch_rate, yaw_rate, roll_angle, pitch_angle, 2 zero bits
    output logic [imt_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                           cfg_we,
    input  logic [imt_pkg::CFG_A_W-1:0]    cfg_addr,
    input  logic [imt_pkg::CFG_D_W-1:0]    cfg_wdata
);
    import imt_pkg::*;

    localparam int LAT = CORDIC_STAGES + SQRT_STEPS + 2;

    logic          ce;
    logic [LAT-1:0] vld_reg;
    axis_t         ax, ay, az, gx, gy, gz;
    axis_t         roll_r, pitch_r, yaw_r;
    angle_t        roll_a, pitch_a;
    logic          ovr_en_reg;
    axis_t         ovr_roll_r_reg, ovr_pitch_r_reg, ovr_yaw_r_reg;
    angle_t        ovr_roll_a_reg, ovr_pitch_a_reg;
    angle_t        ovr_roll_sat, ovr_pitch_sat;

    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;
    assign m_tvalid = vld_reg[LAT-1];

    assign ax = s_tdata[15:0];
    assign ay = s_tdata[31:16];
    assign az = s_tdata[47:32];
    assign gx = s_tdata[63:48];
    assign gy = s_tdata[79:64];
    assign gz = s_tdata[95:80];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovr_en_reg      <= 1'b0;
            ovr_roll_r_reg  <= '0;
            ovr_pitch_r_reg <= '0;
            ovr_yaw_r_reg   <= '0;
            ovr_roll_a_reg  <= '0;
            ovr_pitch_a_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_OVR_EN:      ovr_en_reg      <= cfg_wdata[0];
                REG_OVR_ROLL_R:  ovr_roll_r_reg  <= cfg_wdata;
                REG_OVR_PITCH_R: ovr_pitch_r_reg <= cfg_wdata;
                REG_OVR_YAW_R:   ovr_yaw_r_reg   <= cfg_wdata;
                REG_OVR_ROLL_A:  ovr_roll_a_reg  <= cfg_wdata[ANGLE_W-1:0];
                REG_OVR_PITCH_A: ovr_pitch_a_reg <= cfg_wdata[ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    imt_tilt #(.CS(CORDIC_STAGES)) u_roll (
        .aclk (aclk), .ce (ce), .n (ay), .a (ax), .b (az), .angle (roll_a)
    );

    imt_tilt #(.CS(CORDIC_STAGES)) u_pitch (
        .aclk (aclk), .ce (ce), .n (ax), .a (ay), .b (az), .angle (pitch_a)
    );

    imt_rate #(.DELAY(LAT - RATE_STAGES)) u_rate_x (
        .aclk (aclk), .ce (ce), .g (gx), .rate (roll_r)
    );

    imt_rate #(.DELAY(LAT - RATE_STAGES)) u_rate_y (
        .aclk (aclk), .ce (ce), .g (gy), .rate (pitch_r)
    );

    imt_rate #(.DELAY(LAT - RATE_STAGES)) u_rate_z (
        .aclk (aclk), .ce (ce), .g (gz), .rate (yaw_r)
    );

    assign ovr_roll_sat  = (ovr_roll_a_reg > ANGLE_LIMIT) ? ANGLE_LIMIT :
                           (ovr_roll_a_reg < -ANGLE_LIMIT) ? -ANGLE_LIMIT : ovr_roll_a_reg;
    assign ovr_pitch_sat = (ovr_pitch_a_reg > ANGLE_LIMIT) ? ANGLE_LIMIT :
                           (ovr_pitch_a_reg < -ANGLE_LIMIT) ? -ANGLE_LIMIT : ovr_pitch_a_reg;

    always_comb begin
        if (ovr_en_reg) begin
            m_tdata = {2'b00, ovr_pitch_sat, ovr_roll_sat,
                       ovr_yaw_r_reg, ovr_pitch_r_reg, ovr_roll_r_reg};
        end else begin
            m_tdata = {2'b00, angle_t'(-pitch_a), roll_a, yaw_r, pitch_r, roll_r};
        end
    end

endmodule

[src/imt_isqrt.sv]
`timescale 1ns / 1ps
// Pipelined integer square root of (sum * 65536), one result bit per stage.
// Depends on imt_pkg.
module imt_isqrt #(
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              ce,
    input  logic [31:0]       sum_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic [23:0]       root_out,
    output logic [SIDE_W-1:0] side_out
);
    import imt_pkg::*;

    logic [27:0]       rem_reg  [0:SQRT_STEPS-1];
    logic [23:0]       root_reg [0:SQRT_STEPS-1];
    logic [31:0]       sum_reg  [0:SQRT_STEPS-1];
    logic [SIDE_W-1:0] side_reg [0:SQRT_STEPS-1];

    genvar i;
    generate
        for (i = 0; i < SQRT_STEPS; i++) begin : g_step
            logic [27:0]       rem_in;
            logic [23:0]       root_in;
            logic [31:0]       sm_in;
            logic [SIDE_W-1:0] sd_in;
            logic [1:0]        pair;
            logic [27:0]       rem_sh;
            logic [27:0]       trial;
            logic              ge;

            if (i == 0) begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign sm_in   = sum_in;
                assign sd_in   = side_in;
            end else begin : g_next
                assign rem_in  = rem_reg[i-1];
                assign root_in = root_reg[i-1];
                assign sm_in   = sum_reg[i-1];
                assign sd_in   = side_reg[i-1];
            end

            if (i < 16) begin : g_pair
                assign pair = sm_in[31-2*i -: 2];
            end else begin : g_zero
                assign pair = 2'b00;
            end

            assign rem_sh = {rem_in[25:0], pair};
            assign trial  = {2'b00, root_in, 2'b01};
            assign ge     = (rem_sh >= trial);

            always_ff @(posedge aclk) begin
                if (ce) begin
                    rem_reg[i]  <= ge ? (rem_sh - trial) : rem_sh;
                    root_reg[i] <= {root_in[22:0], ge};
                    sum_reg[i]  <= sm_in;
                    side_reg[i] <= sd_in;
                end
            end
        end
    endgenerate

    assign root_out = root_reg[SQRT_STEPS-1];
    assign side_out = side_reg[SQRT_STEPS-1];

endmodule

[src/imt_cordic.sv]
`timescale 1ns / 1ps
// Pipelined vectoring CORDIC, one micro-rotation per stage; angle in 1/65536 degree.
// Depends on imt_pkg.
module imt_cordic #(
    parameter int CS = imt_pkg::CORDIC_STAGES_DEF
) (
    input  logic               aclk,
    input  logic               ce,
    input  logic signed [27:0] x_in,
    input  logic signed [27:0] y_in,
    input  logic               side_in,
    output logic signed [24:0] z_out,
    output logic               side_out
);
    import imt_pkg::*;

    logic signed [27:0] x_reg    [0:CS-1];
    logic signed [27:0] y_reg    [0:CS-1];
    logic signed [24:0] z_reg    [0:CS-1];
    logic               side_reg [0:CS-1];

    genvar i;
    generate
        for (i = 0; i < CS; i++) begin : g_stage
            logic signed [27:0] xi, yi, dx, dy;
            logic signed [24:0] zi, tv;
            logic               si;

            if (i == 0) begin : g_first
                assign xi = x_in;
                assign yi = y_in;
                assign zi = '0;
                assign si = side_in;
            end else begin : g_next
                assign xi = x_reg[i-1];
                assign yi = y_reg[i-1];
                assign zi = z_reg[i-1];
                assign si = side_reg[i-1];
            end

            assign dx = yi >>> i;
            assign dy = xi >>> i;
            assign tv = signed'({3'b000, imt_atan(i)});

            always_ff @(posedge aclk) begin
                if (ce) begin
                    if (!yi[27]) begin
                        x_reg[i] <= xi + dx;
                        y_reg[i] <= yi - dy;
                        z_reg[i] <= zi + tv;
                    end else begin
                        x_reg[i] <= xi - dx;
                        y_reg[i] <= yi + dy;
                        z_reg[i] <= zi - tv;
                    end
                    side_reg[i] <= si;
                end
            end
        end
    endgenerate

    assign z_out    = z_reg[CS-1];
    assign side_out = side_reg[CS-1];

endmodule

[src/imt_tilt.sv]
`timescale 1ns / 1ps
// One tilt angle: atan2(n, sqrt(a^2 + b^2)) in 1/128 degree, rounded and saturated.
// Depends on imt_pkg, imt_isqrt, imt_cordic.
module imt_tilt #(
    parameter int CS = imt_pkg::CORDIC_STAGES_DEF
) (
    input  logic                  aclk,
    input  logic                  ce,
    input  imt_pkg::axis_t        n,
    input  imt_pkg::axis_t        a,
    input  imt_pkg::axis_t        b,
    output imt_pkg::angle_t       angle
);
    import imt_pkg::*;

    logic signed [31:0] pa, pb;
    logic [31:0]        sum_reg;
    logic [23:0]        y0_reg;
    logic               zero0_reg;
    logic [23:0]        root;
    logic [24:0]        sq_side;
    logic signed [27:0] cx, cy;
    logic signed [24:0] z;
    logic               zero_c;
    logic signed [25:0] z_ext, z_mag, r_pos, r_neg, r;
    angle_t             angle_next, angle_reg;

    assign pa = a * a;
    assign pb = b * b;

    always_ff @(posedge aclk) begin
        if (ce) begin
            sum_reg   <= unsigned'(pa) + unsigned'(pb);
            y0_reg    <= {n, 8'h00};
            zero0_reg <= (n == '0);
        end
    end

    imt_isqrt #(.SIDE_W(25)) u_isqrt (
        .aclk     (aclk),
        .ce       (ce),
        .sum_in   (sum_reg),
        .side_in  ({zero0_reg, y0_reg}),
        .root_out (root),
        .side_out (sq_side)
    );

    assign cx = signed'({4'b0000, root});
    assign cy = signed'({{4{sq_side[23]}}, sq_side[23:0]});

    imt_cordic #(.CS(CS)) u_cordic (
        .aclk     (aclk),
        .ce       (ce),
        .x_in     (cx),
        .y_in     (cy),
        .side_in  (sq_side[24]),
        .z_out    (z),
        .side_out (zero_c)
    );

    // halves away from zero
    always_comb begin
        z_ext = {z[24], z};
        z_mag = -z_ext;
        r_pos = (z_ext + 26'sd256) >>> 9;
        r_neg = -((z_mag + 26'sd256) >>> 9);
        r     = z[24] ? r_neg : r_pos;
        if (zero_c) begin
            angle_next = '0;
        end else if (r > 26'sd11520) begin
            angle_next = ANGLE_LIMIT;
        end else if (r < -26'sd11520) begin
            angle_next = -ANGLE_LIMIT;
        end else begin
            angle_next = r[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg;

endmodule

[src/imt_rate.sv]
`timescale 1ns / 1ps
// Gyro count to 1/128 deg/s: round(g * 128 / 131) by reciprocal multiply, then delay.
// Depends on imt_pkg.
module imt_rate #(
    parameter int DELAY = 1
) (
    input  logic            aclk,
    input  logic            ce,
    input  imt_pkg::axis_t  g,
    output imt_pkg::axis_t  rate
);
    import imt_pkg::*;

    logic signed [16:0] gs;
    logic [16:0]        mag;
    logic [23:0]        x_reg;
    logic               neg1_reg, neg2_reg;
    logic [47:0]        prod_reg;
    logic [16:0]        q;
    axis_t              r_reg;
    axis_t              dly_reg [0:DELAY-1];

    assign gs  = {g[15], g};
    assign mag = unsigned'(g[15] ? -gs : gs);
    assign q   = prod_reg[46:30];

    always_ff @(posedge aclk) begin
        if (ce) begin
            x_reg    <= {mag, 7'b0000000} + RATE_BIAS;
            neg1_reg <= g[15];
            prod_reg <= 48'(x_reg) * 48'(RATE_RECIP);
            neg2_reg <= neg1_reg;
            r_reg    <= neg2_reg ? -signed'(q[15:0]) : signed'(q[15:0]);
        end
    end

    genvar i;
    generate
        for (i = 0; i < DELAY; i++) begin : g_dly
            always_ff @(posedge aclk) begin
                if (ce) begin
                    dly_reg[i] <= (i == 0) ? r_reg : dly_reg[(i == 0) ? 0 : i-1];
                end
            end
        end
    endgenerate

    assign rate = dly_reg[DELAY-1];

endmodule
